// ----- rtl/core/tslf_pkg.sv -----
// ----------------------------------------------------------------------------
// tslf_pkg: shared types and constants of the text stream line filter
// Byte codes, register indexes, the command passed from front to back and
// the BCD line counter helpers.
// ----------------------------------------------------------------------------
package tslf_pkg;

	// line number field
	localparam int NUMBER_DIGITS = 6;
	localparam int COUNT_W       = 4 * NUMBER_DIGITS;
	localparam int DIG_W         = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
	// positions within one burst: digits, tab, first byte, second byte
	localparam int POS_W         = $clog2(NUMBER_DIGITS + 3);

	// command queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUMBER_MODE      = 3'd0,
		REG_SQUEEZE_BLANK    = 3'd1,
		REG_SHOW_NONPRINTING = 3'd2,
		REG_SHOW_ENDS        = 3'd3,
		REG_SHOW_TABS        = 3'd4
	} cfg_reg_e;

	// byte codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_I      = 8'h49;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DEL    = 8'h7F;
	localparam logic [7:0] CTRL_MAX  = 8'h1F;
	localparam logic [7:0] CTRL_FLIP = 8'h40;

	// one classified input beat, ready to be expanded into output beats
	typedef struct packed {
		logic               has_prefix;
		logic               two_bytes;
		logic [7:0]         byte0;
		logic [7:0]         byte1;
		logic [COUNT_W-1:0] count;
	} cmd_t;

	function automatic logic [COUNT_W-1:0] all_nines();
		logic [COUNT_W-1:0] v;
		v = '0;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			v[4*i +: 4] = 4'd9;
		end
		return v;
	endfunction

	// saturating BCD increment
	function automatic logic [COUNT_W-1:0] bcd_inc(input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] v;
		logic               carry;
		logic [3:0]         d;
		v     = cnt;
		carry = 1'b1;
		if (cnt != all_nines()) begin
			for (int i = 0; i < NUMBER_DIGITS; i++) begin
				d = cnt[4*i +: 4];
				if (carry) begin
					if (d >= 4'd9) begin
						v[4*i +: 4] = 4'd0;
					end else begin
						v[4*i +: 4] = d + 4'd1;
						carry       = 1'b0;
					end
				end
			end
		end
		return v;
	endfunction

endpackage

// ----- rtl/core/tslf_front.sv -----
// ----------------------------------------------------------------------------
// tslf_front: input classifier
// Holds the mode registers and the line state, takes one input beat per cycle
// while q_full is low and turns it into a command for the output sequencer.
// ----------------------------------------------------------------------------
module tslf_front import tslf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic [7:0]            in_byte,
	input  logic                  in_file_start,
	input  logic                  q_full,
	output logic                  in_ready,
	output logic                  push,
	output cmd_t                  push_cmd
);

	logic [1:0]         number_mode_q;
	logic               squeeze_blank_q;
	logic               show_nonprinting_q;
	logic               show_ends_q;
	logic               show_tabs_q;

	logic               after_nl_q;
	logic               blank_seen_q;
	logic [COUNT_W-1:0] count_q;

	logic               accept;
	logic               nl;
	logic               an_eff;
	logic               bs_eff;
	logic [COUNT_W-1:0] cnt_eff;
	logic               bs_next;
	logic [COUNT_W-1:0] cnt_next;
	logic               drop;
	cmd_t               cmd;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q      <= '0;
			squeeze_blank_q    <= 1'b0;
			show_nonprinting_q <= 1'b0;
			show_ends_q        <= 1'b0;
			show_tabs_q        <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUMBER_MODE:      number_mode_q      <= cfg_wdata[1:0];
				REG_SQUEEZE_BLANK:    squeeze_blank_q    <= cfg_wdata[0];
				REG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_wdata[0];
				REG_SHOW_ENDS:        show_ends_q        <= cfg_wdata[0];
				REG_SHOW_TABS:        show_tabs_q        <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// classify the incoming byte
	always_comb begin
		nl       = (in_byte == CH_NL);
		an_eff   = in_file_start ? 1'b1 : after_nl_q;
		bs_eff   = in_file_start ? 1'b0 : blank_seen_q;
		cnt_eff  = in_file_start ? '0 : count_q;
		bs_next  = bs_eff;
		cnt_next = cnt_eff;
		drop     = 1'b0;

		cmd            = '0;
		cmd.byte0      = in_byte;
		cmd.byte1      = in_byte;
		cmd.count      = cnt_eff;

		if (number_mode_q != 2'd0) begin
			if (an_eff && (!number_mode_q[1] || !nl)) begin
				cnt_next       = bcd_inc(cnt_eff);
				cmd.has_prefix = 1'b1;
			end
			cmd.count = cnt_next;
		end else if (squeeze_blank_q) begin
			if (an_eff) begin
				if (nl) begin
					drop    = bs_eff;
					bs_next = 1'b1;
				end else begin
					bs_next = 1'b0;
				end
			end
		end else if (show_nonprinting_q) begin
			if (in_byte <= CTRL_MAX && !nl && in_byte != CH_TAB) begin
				cmd.two_bytes = 1'b1;
				cmd.byte0     = CH_CARET;
				cmd.byte1     = in_byte ^ CTRL_FLIP;
			end else if (in_byte == CH_TAB && show_tabs_q) begin
				cmd.two_bytes = 1'b1;
				cmd.byte0     = CH_CARET;
				cmd.byte1     = CH_I;
			end else if (nl && show_ends_q) begin
				cmd.two_bytes = 1'b1;
				cmd.byte0     = CH_DOLLAR;
				cmd.byte1     = CH_NL;
			end else if (in_byte == CH_DEL) begin
				cmd.two_bytes = 1'b1;
				cmd.byte0     = CH_CARET;
				cmd.byte1     = CH_QMARK;
			end
		end else begin
			if (nl && show_ends_q) begin
				cmd.two_bytes = 1'b1;
				cmd.byte0     = CH_DOLLAR;
				cmd.byte1     = CH_NL;
			end else if (in_byte == CH_TAB && show_tabs_q) begin
				cmd.two_bytes = 1'b1;
				cmd.byte0     = CH_CARET;
				cmd.byte1     = CH_I;
			end
		end
	end

	assign push     = accept && !drop;
	assign push_cmd = cmd;

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_nl_q   <= 1'b1;
			blank_seen_q <= 1'b0;
			count_q      <= '0;
		end else if (accept) begin
			after_nl_q   <= nl;
			blank_seen_q <= bs_next;
			count_q      <= cnt_next;
		end
	end

endmodule

// ----- rtl/core/tslf_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// tslf_cmd_fifo: command queue
// Short register queue between the classifier and the output sequencer.
// ----------------------------------------------------------------------------
module tslf_cmd_fifo import tslf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// overflow and underflow checks
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("cmd fifo push while full");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("cmd fifo pop while empty");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
		else $error("cmd fifo level out of range");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("cmd fifo level did not follow push");

endmodule

// ----- rtl/core/tslf_back.sv -----
// ----------------------------------------------------------------------------
// tslf_back: output sequencer
// Expands the command at the queue head into output beats, one per cycle
// while the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module tslf_back import tslf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  logic       empty,
	output logic       pop,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [7:0] out_byte,
	output logic       out_last
);

	localparam logic [POS_W-1:0] POS_TAB   = POS_W'(NUMBER_DIGITS);
	localparam logic [POS_W-1:0] POS_BYTE0 = POS_W'(NUMBER_DIGITS + 1);
	localparam logic [POS_W-1:0] POS_BYTE1 = POS_W'(NUMBER_DIGITS + 2);

	logic [POS_W-1:0]         pos_q;
	logic                     out_valid_q;
	logic [7:0]               out_byte_q;
	logic                     out_last_q;

	logic [POS_W-1:0]         pos_eff;
	logic [DIG_W-1:0]         dig_idx;
	logic [3:0]               digit;
	logic [NUMBER_DIGITS-1:0] nz_above;
	logic                     load;
	logic                     is_last;
	logic [7:0]               cur_byte;

	// digits at or above each place that are nonzero
	always_comb begin
		nz_above[NUMBER_DIGITS-1] = (head.count[4*(NUMBER_DIGITS-1) +: 4] != 4'd0);
		for (int i = NUMBER_DIGITS - 2; i >= 0; i--) begin
			nz_above[i] = nz_above[i+1] || (head.count[4*i +: 4] != 4'd0);
		end
	end

	// select the byte at the current position
	always_comb begin
		pos_eff  = head.has_prefix ? pos_q : pos_q + POS_BYTE0;
		dig_idx  = DIG_W'(NUMBER_DIGITS - 1) - DIG_W'(pos_eff);
		digit    = head.count[4*dig_idx +: 4];
		is_last  = head.two_bytes ? (pos_eff == POS_BYTE1) : (pos_eff == POS_BYTE0);
		if (pos_eff < POS_TAB) begin
			if (!nz_above[dig_idx] && dig_idx != '0) begin
				cur_byte = CH_SPACE;
			end else begin
				cur_byte = CH_ZERO | {4'd0, digit};
			end
		end else if (pos_eff == POS_TAB) begin
			cur_byte = CH_TAB;
		end else if (pos_eff == POS_BYTE0) begin
			cur_byte = head.byte0;
		end else begin
			cur_byte = head.byte1;
		end
	end

	assign load = !out_valid_q || out_ready;
	assign pop  = load && !empty && is_last;

	// output stage and burst position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				pos_q <= is_last ? '0 : pos_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_byte_q <= cur_byte;
			out_last_q <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;

endmodule

// ----- rtl/core/text_stream_line_filter_unit.sv -----
// ----------------------------------------------------------------------------
// text_stream_line_filter_unit: cat-style byte stream filter
// Line numbering, blank line squeezing and caret notation on a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one text byte per beat in tdata and the start-of-file flag
//   in tuser. m_axis returns the transformed bytes, one per beat; tlast marks
//   the final output byte caused by an input byte. A byte dropped by squeeze
//   mode gives no output beat at all.
//   The mode registers are written through cfg_we/cfg_index/cfg_wdata while
//   the stream is idle.
//   The first output byte of an input is written into the queue when the
//   input beat is accepted, then loaded into the output register, where it
//   is held until the receiver takes it.
//   Throughput: one output beat per cycle from the output sequencer while the
//   receiver is ready; an input byte gives one beat per output byte (up to
//   eight with a line number prefix), so plain bytes flow at one per cycle.
//   When the receiver stalls, the output register holds and the four-entry
//   command queue fills; s_axis_tready drops once it is full.
//   Reset clears the modes, sets the line-start state, zeroes the count and
//   empties the queue.
// ----------------------------------------------------------------------------
module text_stream_line_filter_unit import tslf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	// input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] data_byte
	input  logic [0:0]            s_axis_tuser,  // [0] file_start
	// output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [7:0]            m_axis_tdata,  // [7:0] out_byte
	output logic                  m_axis_tlast   // last_of_run
);

	logic push;
	cmd_t push_cmd;
	logic pop;
	cmd_t head;
	logic full;
	logic empty;

	// classifier
	tslf_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (s_axis_tvalid),
		.in_byte       (s_axis_tdata),
		.in_file_start (s_axis_tuser[0]),
		.q_full        (full),
		.in_ready      (s_axis_tready),
		.push          (push),
		.push_cmd      (push_cmd)
	);

	// command queue
	tslf_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.full     (full),
		.empty    (empty)
	);

	// output sequencer
	tslf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ----- test/text_stream_line_filter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// text_stream_line_filter_unit_tb: self-checking bench of the line filter
// Streams text bytes into the filter under fixed and random mode settings and
// compares each output beat with a behavioral model of the filter kept in the
// bench. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module text_stream_line_filter_unit_tb import tslf_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int TIMEOUT_NS    = 10_000_000;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 100;
	localparam int COUNT_LINES   = 100;

	// number_mode register values; bit 1 selects non-blank numbering
	localparam logic [1:0] NUM_OFF      = 2'd0;
	localparam logic [1:0] NUM_ALL      = 2'd1;
	localparam logic [1:0] NUM_NONBLANK = 2'd2;

	// first register index past the implemented ones
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = 3'd5;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_beat_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;  // [7:0] data_byte
	logic [0:0]            s_axis_tuser;  // [0] file_start
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [7:0]            m_axis_tdata;  // [7:0] out_byte
	logic                  m_axis_tlast;  // last_of_run

	// filter model state
	logic [1:0]         number_mode;
	logic               squeeze_blank;
	logic               show_nonprinting;
	logic               show_ends;
	logic               show_tabs;
	logic               at_line_start;
	logic [COUNT_W-1:0] line_no;
	logic               empty_line_seen;

	out_beat_t filtered_due[$];
	int        error_count;
	bit        tx_calm;
	bit        rx_calm;
	int        rx_stall_left = 0;

	text_stream_line_filter_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// idle length: mostly none, some short, a few long
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// saturating BCD line number increment
	function automatic logic [COUNT_W-1:0] bump_line_no(input logic [COUNT_W-1:0] n);
		logic [COUNT_W-1:0] r;
		logic               carry;
		r     = n;
		carry = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			if (carry) begin
				if (r[4*i +: 4] == 4'd9) begin
					r[4*i +: 4] = 4'd0;
				end else begin
					r[4*i +: 4] = r[4*i +: 4] + 4'd1;
					carry       = 1'b0;
				end
			end
		end
		// every digit rolled over: the count is full and holds
		return carry ? n : r;
	endfunction

	// mirror of one register write
	task automatic store_setting(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] v);
		case (idx)
			REG_NUMBER_MODE: begin
				number_mode = v;
			end
			REG_SQUEEZE_BLANK: begin
				squeeze_blank = v[0];
			end
			REG_SHOW_NONPRINTING: begin
				show_nonprinting = v[0];
			end
			REG_SHOW_ENDS: begin
				show_ends = v[0];
			end
			REG_SHOW_TABS: begin
				show_tabs = v[0];
			end
			default: begin
			end
		endcase
	endtask

	// expected output beats of one accepted input byte
	task automatic filter_text_byte(input logic [7:0] ch, input logic fs);
		logic [7:0] burst[$];
		logic       nl;
		logic       lead;
		logic [3:0] dig;
		nl = (ch == CH_NL);
		if (fs) begin
			line_no         = '0;
			at_line_start   = 1'b1;
			empty_line_seen = 1'b0;
		end
		if (number_mode != NUM_OFF) begin
			// numbering: prefix at line start, or only for non-blank lines
			if (at_line_start && (!number_mode[1] || !nl)) begin
				line_no = bump_line_no(line_no);
				lead    = 1'b1;
				for (int i = NUMBER_DIGITS - 1; i >= 0; i--) begin
					dig = line_no[4*i +: 4];
					if (dig != 4'd0 || i == 0)
						lead = 1'b0;
					burst.push_back(lead ? CH_SPACE : CH_ZERO + {4'd0, dig});
				end
				burst.push_back(CH_TAB);
			end
			burst.push_back(ch);
		end else if (squeeze_blank) begin
			// squeeze: second and later empty lines in a run vanish
			if (at_line_start && nl) begin
				if (!empty_line_seen)
					burst.push_back(ch);
				empty_line_seen = 1'b1;
			end else begin
				if (at_line_start)
					empty_line_seen = 1'b0;
				burst.push_back(ch);
			end
		end else if (show_nonprinting) begin
			// caret notation
			if (ch <= CTRL_MAX && !nl && ch != CH_TAB) begin
				burst.push_back(CH_CARET);
				burst.push_back(ch ^ CTRL_FLIP);
			end
			if (ch == CH_TAB && show_tabs) begin
				burst.push_back(CH_CARET);
				burst.push_back(CH_I);
			end
			if (nl) begin
				if (show_ends)
					burst.push_back(CH_DOLLAR);
				burst.push_back(CH_NL);
			end
			if ((ch >= CH_SPACE && ch != CH_DEL) || (ch == CH_TAB && !show_tabs))
				burst.push_back(ch);
			if (ch == CH_DEL) begin
				burst.push_back(CH_CARET);
				burst.push_back(CH_QMARK);
			end
		end else begin
			// plain path: only end marks and visible tabs
			if (nl && show_ends)
				burst.push_back(CH_DOLLAR);
			if (ch == CH_TAB && show_tabs) begin
				burst.push_back(CH_CARET);
				burst.push_back(CH_I);
			end else begin
				burst.push_back(ch);
			end
		end
		at_line_start = nl;
		foreach (burst[k])
			filtered_due.push_back('{out_byte: burst[k], last_of_run: k == burst.size() - 1});
	endtask

	// one input beat; tvalid stays high when the next beat follows at once
	task automatic send_byte(input logic [7:0] b, input logic fs);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= fs;
		do
			@(posedge clk);
		while (!s_axis_tready);
		filter_text_byte(b, fs);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], 1'b0);
	endtask

	// stop sending and wait for every expected beat, then for the pipeline
	task automatic wait_drained();
		int n;
		n = 0;
		s_axis_tvalid <= 1'b0;
		while (filtered_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		if (filtered_due.size() != 0) begin
			$error("%0d expected output beats never arrived", filtered_due.size());
			error_count++;
			filtered_due.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [1:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		store_setting(idx, v);
	endtask

	// writes all registers, plus one unimplemented index that must be ignored
	task automatic apply_settings(input logic [1:0] mode, input logic [1:0] sq,
			input logic [1:0] np, input logic [1:0] ends, input logic [1:0] tabs);
		put_reg(REG_NUMBER_MODE, mode);
		put_reg(REG_SQUEEZE_BLANK, sq);
		put_reg(REG_SHOW_NONPRINTING, np);
		put_reg(REG_SHOW_ENDS, ends);
		put_reg(REG_SHOW_TABS, tabs);
		put_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_FIRST, {CFG_IDX_W{1'b1}})),
			2'($urandom_range(0, 3)));
		cfg_we <= 1'b0;
	endtask

	// receiver with random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (rx_calm) begin
			m_axis_tready <= 1'b1;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			rx_stall_left = pick_gap(1'b0);
		end
	end

	// output beat check
	always @(posedge clk) begin : out_check
		out_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (filtered_due.size() == 0) begin
				$error("unexpected output beat: out_byte %h last_of_run %b",
					m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				want = filtered_due.pop_front();
				if (m_axis_tdata !== want.out_byte) begin
					$error("out_byte: expected %h, got %h", want.out_byte, m_axis_tdata);
					error_count++;
				end
				if (m_axis_tlast !== want.last_of_run) begin
					$error("last_of_run: expected %b, got %b", want.last_of_run, m_axis_tlast);
					error_count++;
				end
			end
		end
	end

	// plain path: pass-through, then visible ends and tabs
	task automatic test_plain_path();
		apply_settings(NUM_OFF, 2'd0, 2'd0, 2'd0, 2'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_NL, 1'b1);
		wait_drained();
		apply_settings(NUM_OFF, 2'd0, 2'd0, 2'd1, 2'd1);
		send_text("\t\n");
		wait_drained();
	endtask

	// caret notation of control bytes, DEL, tabs and line ends
	task automatic test_caret_notation();
		apply_settings(NUM_OFF, 2'd0, 2'd1, 2'd1, 2'd0);
		send_byte(8'h00, 1'b0);
		send_byte(CTRL_MAX, 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(CH_DEL, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(CH_NL, 1'b0);
		wait_drained();
		apply_settings(NUM_OFF, 2'd0, 2'd1, 2'd0, 2'd1);
		send_byte(CH_TAB, 1'b0);
		wait_drained();
	endtask

	// squeeze wins over caret notation; the last newline starts a new file
	task automatic test_squeeze_blank();
		apply_settings(NUM_OFF, 2'd1, 2'd1, 2'd1, 2'd1);
		send_text("a\n\n\n\nb\n");
		send_byte(CH_NL, 1'b1);
		wait_drained();
	endtask

	// all-lines, non-blank and mode three numbering; other flags have no effect
	task automatic test_line_numbering();
		apply_settings(NUM_ALL, 2'd1, 2'd1, 2'd1, 2'd1);
		send_text("\n\t\n");
		wait_drained();
		apply_settings(NUM_NONBLANK | NUM_ALL, 2'd0, 2'd0, 2'd0, 2'd0);
		send_text("\nc\n");
		wait_drained();
		apply_settings(NUM_NONBLANK, 2'd0, 2'd0, 2'd0, 2'd0);
		send_byte("d", 1'b1);
		send_byte(CH_NL, 1'b0);
		wait_drained();
	endtask

	// count carries across several digits, with no idling on either side
	task automatic test_count_carry();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		apply_settings(NUM_ALL, 2'd0, 2'd0, 2'd0, 2'd0);
		send_byte(CH_NL, 1'b1);
		repeat (COUNT_LINES - 1) send_byte(CH_NL, 1'b0);
		send_text("z\n");
		wait_drained();
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return CH_NL;
		if (r < 18)
			return CH_TAB;
		if (r < 30)
			return 8'($urandom_range(0, CTRL_MAX));
		if (r < 36)
			return CH_DEL;
		if (r < 50)
			return 8'($urandom_range(8'h80, 8'hFF));
		return 8'($urandom_range(CH_SPACE, CH_DEL - 1));
	endfunction

	// random lines of random text under random settings, extremes first
	task automatic test_random_text();
		int         sent;
		int         phase;
		int         phase_end;
		int         len;
		logic [1:0] mode;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			if (phase == 0) begin
				apply_settings(2'd3, 2'd3, 2'd3, 2'd3, 2'd3);
			end else if (phase == 1) begin
				apply_settings(NUM_OFF, 2'd0, 2'd0, 2'd0, 2'd0);
			end else begin
				mode = ($urandom_range(0, 1) == 0) ? NUM_OFF : 2'($urandom_range(1, 3));
				apply_settings(mode, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			end
			tx_calm   = ($urandom_range(0, 3) == 0);
			rx_calm   = ($urandom_range(0, 3) == 0);
			phase_end = sent + $urandom_range(20, 40);
			while (sent < phase_end) begin
				len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				repeat (len) begin
					send_byte(pick_text_byte(), $urandom_range(0, 29) == 0);
					sent++;
				end
				send_byte(CH_NL, $urandom_range(0, 29) == 0);
				sent++;
			end
			wait_drained();
			phase++;
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// main sequence
	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= REG_NUMBER_MODE;
		cfg_wdata        <= '0;
		s_axis_tvalid    <= 1'b0;
		s_axis_tdata     <= '0;
		s_axis_tuser     <= '0;
		number_mode      = NUM_OFF;
		squeeze_blank    = 1'b0;
		show_nonprinting = 1'b0;
		show_ends        = 1'b0;
		show_tabs        = 1'b0;
		at_line_start    = 1'b1;
		line_no          = '0;
		empty_line_seen  = 1'b0;
		error_count      = 0;
		tx_calm          = 1'b0;
		rx_calm          = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_plain_path();
		test_caret_notation();
		test_squeeze_blank();
		test_line_numbering();
		test_count_carry();
		test_random_text();

		wait_drained();
		if (error_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#(TIMEOUT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
